// ----- design/lim_pkg.sv -----
// ----------------------------------------------------------------------------
// Lidar intensity model package
// Beat types, status and register codes, fixed-point constants and the
// table of 2^(2^-i) values used by the power-of-two pipelines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lim_pkg;

  localparam int FRAC_W = 24;

  typedef struct packed {
    logic [31:0] target_range;
    logic [23:0] reflectance;
    logic [21:0] laser_power;
  } in_beat_t;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_ZERO_RANGE = 2'd1;
  localparam status_t STATUS_SATURATED  = 2'd2;

  typedef struct packed {
    logic [31:0] predicted_count;
    status_t     status;
  } out_beat_t;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t CFG_GAIN_SLOPE      = 3'd0;
  localparam cfg_index_t CFG_GAIN_OFFSET     = 3'd1;
  localparam cfg_index_t CFG_SATURATION_RATE = 3'd2;
  localparam cfg_index_t CFG_RANGE_EXPONENT  = 3'd3;
  localparam cfg_index_t CFG_NEAR_RANGE_RATE = 3'd4;

  localparam int CFG_DATA_W = 27;

  localparam logic [24:0] GAIN_SLOPE_RST      = 25'd3840000;
  localparam logic [21:0] GAIN_OFFSET_RST     = 22'd128000;
  localparam logic [26:0] SATURATION_RATE_RST = 27'd13107200;
  localparam logic [18:0] RANGE_EXPONENT_RST  = 19'd98304;
  localparam logic [25:0] NEAR_RANGE_RATE_RST = 26'd91750;

  localparam logic [24:0] ONE24         = 25'd1 << FRAC_W;
  localparam logic [30:0] LOG2E_Q30     = 31'd1549082005;
  localparam logic [47:0] EXP_LIMIT_Q22 = 48'd3061841920;
  localparam logic [59:0] EXP_LIMIT_Q40 = 60'd730 << 40;
  localparam logic [55:0] LIN_CAP       = {56{1'b1}};
  localparam logic [62:0] EFF_CAP       = 63'd1 << 62;

  typedef logic [FRAC_W:0][31:0] pow_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = v;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Entry i holds 2^(2^-i) in Q.30, each found as the square root of the one before.
  function automatic pow_tab_t calc_pow_tab();
    pow_tab_t t;
    t[0] = 32'd1 << 31;
    for (int i = 1; i <= FRAC_W; i++) begin
      t[i] = 32'(isqrt64(64'(t[i-1]) << 30));
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TAB = calc_pow_tab();

endpackage

// ----- design/lidar_intensity_model_core.sv -----
// Throughput: one input beat per cycle; the three 24-step power-of-two chains and the
// 24 squarings of the logarithm each take one pipeline stage per step.
// Reset: synchronous, active low; it clears the valid bits and loads the register defaults.
// The receiver cannot stall, so busy stays low.
// ----------------------------------------------------------------------------
// Lidar intensity model core
// Predicts the detector count of one lidar return from its range, reflectance
// and laser power, as a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lidar_intensity_model_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  lim_pkg::in_beat_t               in_beat,
  output logic                            out_strobe,
  output lim_pkg::out_beat_t              out_beat,
  input  logic                            cfg_we,
  input  lim_pkg::cfg_index_t             cfg_index,
  input  logic [lim_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int FW        = lim_pkg::FRAC_W;
  localparam int S_PREP_A  = 2;
  localparam int S_CHAIN_A = S_PREP_A + 1;
  localparam int S_FIN_A   = S_CHAIN_A + FW;
  localparam int S_SCALE   = S_FIN_A + 1;
  localparam int S_CHAIN_B = S_SCALE + 1;
  localparam int S_MANT    = S_CHAIN_B + FW;
  localparam int S_EFF     = S_MANT + 1;
  localparam int S_PROD    = S_EFF + 1;
  localparam int S_SUM     = S_PROD + 1;
  localparam int S_PREP_C  = S_SUM + 1;
  localparam int S_CHAIN_C = S_PREP_C + 1;
  localparam int S_FIN_C   = S_CHAIN_C + FW;
  localparam int S_OUTPROD = S_FIN_C + 1;
  localparam int S_OUT     = S_OUTPROD + 1;
  localparam int NST       = S_OUT + 1;

  typedef struct packed {
    logic                 zero;
    logic [31:0]          rng;
    logic [23:0]          rho;
    logic [21:0]          pwr;
    logic [37:0]          pr;
    logic [47:0]          xs;
    logic [4:0]           lp;
    logic [31:0]          lx;
    logic [23:0]          lfrac;
    logic                 ea_sat;
    logic [10:0]          ea_ip;
    logic [23:0]          ea_f;
    logic [31:0]          ea_y;
    logic [24:0]          sr;
    logic                 up;
    logic [28:0]          mag;
    logic [37:0]          base;
    logic [6:0]           sp_ip;
    logic [23:0]          sp_f;
    logic [31:0]          sp_y;
    logic [39:0]          tq;
    logic [62:0]          eff;
    logic [57:0]          keh;
    logic [58:0]          kel;
    logic [55:0]          meh;
    logic [56:0]          mel;
    logic                 eb_sat;
    logic [31:0]          x22;
    logic [10:0]          eb_ip;
    logic [23:0]          eb_f;
    logic [31:0]          eb_y;
    logic [55:0]          lin;
    logic [24:0]          nl;
    logic [48:0]          hinl;
    logic [56:0]          lonl;
    logic [31:0]          count;
    lim_pkg::status_t     status;
  } ctx_t;

  logic [24:0] gain_slope_r;
  logic [21:0] gain_offset_r;
  logic [26:0] saturation_rate_r;
  logic [18:0] range_exponent_r;
  logic [25:0] near_range_rate_r;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  ctx_t           ctx_r   [NST];
  ctx_t           ctx_nxt [NST];

  function automatic logic [31:0] pow_step(input logic [31:0] y, input logic [31:0] tab);
    logic [63:0] prod;
    prod = 64'(y) * 64'(tab);
    return 32'((prod + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic [34:0] exp_arg(input logic [31:0] x);
    logic [62:0] prod;
    prod = 63'(x) * 63'(lim_pkg::LOG2E_Q30);
    return 35'((prod + (63'd1 << 27)) >> 28);
  endfunction

  function automatic logic [24:0] exp_fin(input logic sat, input logic [10:0] ip,
                                          input logic [23:0] f, input logic [31:0] y);
    logic [25:0] mant;
    logic [11:0] sh;
    logic [25:0] e;
    mant = 26'((33'(y) + 33'd32) >> 6);
    sh   = 12'(ip) + 12'(f != '0);
    e    = mant >> sh;
    return sat ? lim_pkg::ONE24 : 25'(26'(lim_pkg::ONE24) - e);
  endfunction

  function automatic ctx_t st_in(input lim_pkg::in_beat_t b);
    ctx_t c;
    c      = '0;
    c.rng  = b.target_range;
    c.rho  = b.reflectance;
    c.pwr  = b.laser_power;
    c.zero = (b.target_range == '0);
    return c;
  endfunction

  function automatic ctx_t st_front(input ctx_t p, input logic [25:0] k2);
    ctx_t       c;
    logic [4:0] lp;
    c  = p;
    lp = '0;
    c.pr = 38'((46'(c.pwr) * 46'(c.rho)) >> 8);
    c.xs = 48'((58'(k2) * 58'(c.rng)) >> 10);
    for (int b = 0; b < 32; b++) begin
      if (c.rng[b]) begin
        lp = 5'(b);
      end
    end
    c.lp    = lp;
    c.lx    = c.rng << (5'd31 - lp);
    c.lfrac = '0;
    return c;
  endfunction

  function automatic ctx_t st_prep_a(input ctx_t p);
    ctx_t        c;
    logic [34:0] y;
    c        = p;
    y        = exp_arg(c.xs[31:0]);
    c.ea_sat = (c.xs >= lim_pkg::EXP_LIMIT_Q22);
    c.ea_ip  = y[34:24];
    c.ea_f   = 24'd0 - y[23:0];
    c.ea_y   = 32'd1 << 30;
    return c;
  endfunction

  function automatic ctx_t st_chain_a(input ctx_t p, input int j);
    ctx_t        c;
    logic [63:0] sq;
    c = p;
    if (c.ea_f[FW-1-j]) begin
      c.ea_y = pow_step(c.ea_y, lim_pkg::POW_TAB[j+1]);
    end
    sq = 64'(c.lx) * 64'(c.lx);
    if (sq[63]) begin
      c.lfrac[FW-1-j] = 1'b1;
      c.lx            = sq[63:32];
    end else begin
      c.lx = sq[62:31];
    end
    return c;
  endfunction

  function automatic ctx_t st_fin_a(input ctx_t p);
    ctx_t               c;
    logic signed [5:0]  pe;
    logic signed [29:0] l;
    c    = p;
    c.sr = exp_fin(c.ea_sat, c.ea_ip, c.ea_f, c.ea_y);
    pe   = $signed({1'b0, c.lp}) - 6'sd16;
    l    = {pe, c.lfrac};
    c.up = l[29];
    c.mag = l[29] ? 29'(-l) : 29'(l);
    return c;
  endfunction

  function automatic ctx_t st_scale(input ctx_t p, input logic [18:0] a);
    ctx_t        c;
    logic [30:0] amag;
    c      = p;
    c.base = 38'((63'(c.pr) * 63'(c.sr) + (63'd1 << 23)) >> 24);
    amag   = 31'((48'(a) * 48'(c.mag) + (48'd1 << 15)) >> 16);
    c.sp_ip = amag[30:24];
    c.sp_f  = c.up ? amag[23:0] : 24'd0 - amag[23:0];
    c.sp_y  = 32'd1 << 30;
    return c;
  endfunction

  function automatic ctx_t st_chain_b(input ctx_t p, input int j);
    ctx_t c;
    c = p;
    if (c.sp_f[FW-1-j]) begin
      c.sp_y = pow_step(c.sp_y, lim_pkg::POW_TAB[j+1]);
    end
    return c;
  endfunction

  function automatic ctx_t st_mant(input ctx_t p);
    ctx_t        c;
    logic [25:0] mant;
    c    = p;
    mant = 26'((33'(c.sp_y) + 33'd32) >> 6);
    c.tq = 40'((64'(c.base) * 64'(mant) + (64'd1 << 23)) >> 24);
    return c;
  endfunction

  function automatic ctx_t st_eff(input ctx_t p);
    ctx_t        c;
    logic [62:0] lim;
    logic [7:0]  sh;
    c   = p;
    lim = lim_pkg::EFF_CAP >> c.sp_ip;
    sh  = 8'(c.sp_ip) + 8'(c.sp_f != '0);
    if (c.up) begin
      if (c.tq == '0) begin
        c.eff = '0;
      end else if (c.sp_ip >= 7'd62 || 63'(c.tq) > lim) begin
        c.eff = lim_pkg::EFF_CAP;
      end else begin
        c.eff = 63'(c.tq) << c.sp_ip;
      end
    end else begin
      c.eff = 63'(c.tq) >> sh;
    end
    return c;
  endfunction

  function automatic ctx_t st_prod(input ctx_t p, input logic [26:0] k, input logic [24:0] m);
    ctx_t c;
    c     = p;
    c.keh = 58'(k) * 58'(c.eff[62:32]);
    c.kel = 59'(k) * 59'(c.eff[31:0]);
    c.meh = 56'(m) * 56'(c.eff[62:32]);
    c.mel = 57'(m) * 57'(c.eff[31:0]);
    return c;
  endfunction

  function automatic ctx_t st_sum(input ctx_t p, input logic [21:0] cofs);
    ctx_t        c;
    logic [59:0] kp;
    logic [64:0] s;
    logic        ovf;
    c        = p;
    kp       = 60'({c.keh[17:0], 32'b0}) + 60'(c.kel);
    c.eb_sat = (|c.keh[57:18]) || (kp >= lim_pkg::EXP_LIMIT_Q40);
    c.x22    = kp[49:18];
    s        = 65'({c.meh[31:0], 32'b0}) + 65'(c.mel) + (65'd1 << 23);
    ovf      = (|c.meh[55:32]) || s[64];
    c.lin    = ovf ? lim_pkg::LIN_CAP : 56'(s[63:24]) + 56'(cofs);
    return c;
  endfunction

  function automatic ctx_t st_prep_c(input ctx_t p);
    ctx_t        c;
    logic [34:0] y;
    c       = p;
    y       = exp_arg(c.x22);
    c.eb_ip = y[34:24];
    c.eb_f  = 24'd0 - y[23:0];
    c.eb_y  = 32'd1 << 30;
    return c;
  endfunction

  function automatic ctx_t st_chain_c(input ctx_t p, input int j);
    ctx_t c;
    c = p;
    if (c.eb_f[FW-1-j]) begin
      c.eb_y = pow_step(c.eb_y, lim_pkg::POW_TAB[j+1]);
    end
    return c;
  endfunction

  function automatic ctx_t st_fin_c(input ctx_t p);
    ctx_t c;
    c    = p;
    c.nl = exp_fin(c.eb_sat, c.eb_ip, c.eb_f, c.eb_y);
    return c;
  endfunction

  function automatic ctx_t st_outprod(input ctx_t p);
    ctx_t c;
    c      = p;
    c.hinl = 49'(c.lin[55:32]) * 49'(c.nl);
    c.lonl = 57'(c.lin[31:0]) * 57'(c.nl);
    return c;
  endfunction

  function automatic ctx_t st_out(input ctx_t p);
    ctx_t        c;
    logic [57:0] dn;
    c  = p;
    dn = 58'({c.hinl, 8'b0}) + 58'((c.lonl + (57'd1 << 23)) >> 24);
    if (c.zero) begin
      c.count  = '1;
      c.status = lim_pkg::STATUS_ZERO_RANGE;
    end else if (|dn[57:32]) begin
      c.count  = '1;
      c.status = lim_pkg::STATUS_SATURATED;
    end else begin
      c.count  = dn[31:0];
      c.status = lim_pkg::STATUS_OK;
    end
    return c;
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_slope_r      <= lim_pkg::GAIN_SLOPE_RST;
      gain_offset_r     <= lim_pkg::GAIN_OFFSET_RST;
      saturation_rate_r <= lim_pkg::SATURATION_RATE_RST;
      range_exponent_r  <= lim_pkg::RANGE_EXPONENT_RST;
      near_range_rate_r <= lim_pkg::NEAR_RANGE_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lim_pkg::CFG_GAIN_SLOPE:      gain_slope_r      <= cfg_wdata[24:0];
        lim_pkg::CFG_GAIN_OFFSET:     gain_offset_r     <= cfg_wdata[21:0];
        lim_pkg::CFG_SATURATION_RATE: saturation_rate_r <= cfg_wdata[26:0];
        lim_pkg::CFG_RANGE_EXPONENT:  range_exponent_r  <= cfg_wdata[18:0];
        lim_pkg::CFG_NEAR_RANGE_RATE: near_range_rate_r <= cfg_wdata[25:0];
        default: begin
        end
      endcase
    end
  end

  assign vld_nxt = {vld_r[NST-2:0], start & ~busy};

  assign ctx_nxt[0]         = st_in(in_beat);
  assign ctx_nxt[1]         = st_front(ctx_r[0], near_range_rate_r);
  assign ctx_nxt[S_PREP_A]  = st_prep_a(ctx_r[S_PREP_A-1]);
  assign ctx_nxt[S_FIN_A]   = st_fin_a(ctx_r[S_FIN_A-1]);
  assign ctx_nxt[S_SCALE]   = st_scale(ctx_r[S_SCALE-1], range_exponent_r);
  assign ctx_nxt[S_MANT]    = st_mant(ctx_r[S_MANT-1]);
  assign ctx_nxt[S_EFF]     = st_eff(ctx_r[S_EFF-1]);
  assign ctx_nxt[S_PROD]    = st_prod(ctx_r[S_PROD-1], saturation_rate_r, gain_slope_r);
  assign ctx_nxt[S_SUM]     = st_sum(ctx_r[S_SUM-1], gain_offset_r);
  assign ctx_nxt[S_PREP_C]  = st_prep_c(ctx_r[S_PREP_C-1]);
  assign ctx_nxt[S_FIN_C]   = st_fin_c(ctx_r[S_FIN_C-1]);
  assign ctx_nxt[S_OUTPROD] = st_outprod(ctx_r[S_OUTPROD-1]);
  assign ctx_nxt[S_OUT]     = st_out(ctx_r[S_OUT-1]);

  for (genvar j = 0; j < FW; j++) begin : g_chain
    assign ctx_nxt[S_CHAIN_A+j] = st_chain_a(ctx_r[S_CHAIN_A+j-1], j);
    assign ctx_nxt[S_CHAIN_B+j] = st_chain_b(ctx_r[S_CHAIN_B+j-1], j);
    assign ctx_nxt[S_CHAIN_C+j] = st_chain_c(ctx_r[S_CHAIN_C+j-1], j);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r <= ctx_nxt;
  end

  assign out_strobe               = vld_r[S_OUT];
  assign out_beat.predicted_count = ctx_r[S_OUT].count;
  assign out_beat.status          = ctx_r[S_OUT].status;

endmodule
